/* hw/rtl/csi_pkg.sv */
`default_nettype none

package csi_pkg;

   localparam int MAX_INTERVALS = 1024;

   localparam int SAMPLE_W   = 32;
   localparam int COUNT_W    = 11;
   localparam int STEP_W     = 32;
   localparam int INTEGRAL_W = 64;
   localparam int REQ_DATA_W = ((SAMPLE_W + COUNT_W + 7) / 8) * 8;

   localparam logic [STEP_W-1:0] STEP_RESET = 32'h0100_0000;

   localparam logic [INTEGRAL_W-1:0] INTEGRAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [INTEGRAL_W-1:0] INTEGRAL_MIN = 64'h8000_0000_0000_0000;

   // long division by three, digit width
   localparam int CHUNK_W = 16;

   localparam int WEIGHT_W = 6;
   typedef logic [WEIGHT_W-1:0] weight_type;

   // weights in units of h/24
   localparam weight_type WEIGHT_NONE      = 6'd0;
   localparam weight_type WEIGHT_TRAP      = 6'd12;
   localparam weight_type WEIGHT_S13_END   = 6'd8;
   localparam weight_type WEIGHT_S13_ODD   = 6'd32;
   localparam weight_type WEIGHT_S13_EVEN  = 6'd16;
   localparam weight_type WEIGHT_S38_END   = 6'd9;
   localparam weight_type WEIGHT_S38_THIRD = 6'd18;
   localparam weight_type WEIGHT_S38_INNER = 6'd27;
   localparam weight_type WEIGHT_JOIN      = 6'd17;

   // accumulator width: |sum| <= 24 * n * 2^31
   function automatic int sum_width(input int max_n);
      return $clog2(24 * max_n) + SAMPLE_W;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/composite_simpson_integrator.sv */
// Streaming composite Simpson integrator. Each beat on req carries one Q8.24
// sample and an interval count n that is read only on the first beat of a run;
// a run is n+1 beats (n clamped to MAX_INTERVALS, n = 0 is a one-beat run with
// a zero result). The rule is Simpson 1/3 for even n, 3/8 for odd multiples of
// three, trapezoid for n = 1, and 1/3 followed by a closing 3/8 panel for other
// odd n. After the last beat of a run one rsp beat carries h * sum / 24 in
// Q16.48, truncated toward zero and clipped to 64 bits, with a saturation flag.
// One sample is taken per cycle with no gaps between runs while rsp is not
// held off. After its last sample is taken a result passes the front-end sum
// and output registers, the scale stages and the long division by 24, which
// produces one 16-bit quotient digit per stage. step_size (csr) is 1.0
// after reset and may only be written while no run is in flight.
`default_nettype none

module composite_simpson_integrator #(
   parameter int MAX_INTERVALS = csi_pkg::MAX_INTERVALS
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [csi_pkg::STEP_W-1:0]         csr_wdata,     // step_size

   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [csi_pkg::REQ_DATA_W-1:0]     req_tdata,     // sample, interval_count

   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [csi_pkg::INTEGRAL_W-1:0]     rsp_tdata,     // integral
   output logic [0:0]                         rsp_tuser      // saturated
);

   localparam int SUM_W  = csi_pkg::sum_width(MAX_INTERVALS);
   localparam int PROD_W = SUM_W - 1 + csi_pkg::STEP_W;

   logic [csi_pkg::STEP_W-1:0] step_size_ff, step_size_in;

   logic                                sample_in;
   logic signed [csi_pkg::SAMPLE_W-1:0] req_sample;
   logic        [csi_pkg::COUNT_W-1:0]  req_count;

   logic                    sum_valid, sum_ready;
   logic signed [SUM_W-1:0] sum_data;
   logic                    prod_valid, prod_ready, prod_neg;
   logic [PROD_W-1:0]       prod_data;
   logic                    rsp_sat;

   assign csr_ready    = 1'b1;
   assign step_size_in = csr_valid ? csr_wdata : step_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff <= csi_pkg::STEP_RESET;
      end else begin
         step_size_ff <= step_size_in;
      end
   end

   assign req_sample = $signed(req_tdata[csi_pkg::SAMPLE_W-1:0]);
   assign req_count  = req_tdata[csi_pkg::SAMPLE_W +: csi_pkg::COUNT_W];
   assign sample_in  = req_tvalid;

   csi_front #(
      .MAX_INTERVALS (MAX_INTERVALS),
      .SUM_W         (SUM_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sample_in),
      .in_ready  (req_tready),
      .in_sample (req_sample),
      .in_count  (req_count),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_sum   (sum_data)
   );

   csi_scale #(
      .SUM_W (SUM_W)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .step_size (step_size_ff),
      .in_valid  (sum_valid),
      .in_ready  (sum_ready),
      .in_sum    (sum_data),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_neg   (prod_neg),
      .out_prod  (prod_data)
   );

   csi_div24 #(
      .PROD_W (PROD_W)
   ) u_div24 (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (prod_valid),
      .in_ready      (prod_ready),
      .in_neg        (prod_neg),
      .in_prod       (prod_data),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_integral  (rsp_tdata),
      .out_saturated (rsp_sat)
   );

   assign rsp_tuser = rsp_sat;

endmodule

`default_nettype wire

/* hw/rtl/csi_front.sv */
`default_nettype none

module csi_front #(
   parameter int MAX_INTERVALS = csi_pkg::MAX_INTERVALS,
   parameter int SUM_W         = csi_pkg::sum_width(csi_pkg::MAX_INTERVALS)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [csi_pkg::SAMPLE_W-1:0] in_sample,
   input  logic        [csi_pkg::COUNT_W-1:0]  in_count,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [SUM_W-1:0]             out_sum
);

   localparam int NW = $clog2(MAX_INTERVALS + 1);
   localparam int MS = NW + 2;
   localparam int MM = (2 ** MS + 2) / 3;
   localparam int MW = NW + MS;
   localparam int TW = csi_pkg::SAMPLE_W + csi_pkg::WEIGHT_W + 1;

   logic [NW-1:0] pos_ff, pos_in, run_n_ff, run_n_in;
   logic [1:0]    pos3_ff, pos3_in;
   logic          run3_ff, run3_in;
   logic [NW-1:0] n_new, n_cur, n_less3, q3;
   logic [MW-1:0] q3_prod;
   logic          n3_new, run3_cur, first, last, accept;
   csi_pkg::weight_type wt;

   logic                                s1_valid_ff, s1_valid_in;
   logic signed [csi_pkg::SAMPLE_W-1:0] s1_sample_ff, s1_sample_in;
   csi_pkg::weight_type                 s1_weight_ff, s1_weight_in;
   logic                                s1_first_ff, s1_first_in;
   logic                                s1_last_ff, s1_last_in;

   logic signed [TW-1:0]    term;
   logic signed [SUM_W-1:0] sum_ff, sum_in, sum_base, sum_next;
   logic                    s1_free, s1_leave, s2_free;
   logic                    out_valid_ff, out_valid_in;
   logic signed [SUM_W-1:0] out_sum_ff, out_sum_in;

   // count clamp and n mod 3 by reciprocal
   always_comb begin
      if (32'(in_count) > 32'(MAX_INTERVALS)) begin
         n_new = NW'(MAX_INTERVALS);
      end else begin
         n_new = NW'(in_count);
      end
      q3_prod = MW'(n_new) * MW'(MM);
      q3      = NW'(q3_prod >> MS);
      n3_new  = (n_new == NW'(32'(q3) * 3));
   end

   assign first    = (pos_ff == '0);
   assign n_cur    = first ? n_new : run_n_ff;
   assign run3_cur = first ? n3_new : run3_ff;
   assign last     = (pos_ff >= n_cur);
   assign n_less3  = n_cur - NW'(3);

   always_comb begin
      if (n_cur == '0) begin
         wt = csi_pkg::WEIGHT_NONE;
      end else if (n_cur == NW'(1)) begin
         wt = csi_pkg::WEIGHT_TRAP;
      end else if (!n_cur[0]) begin
         if (first || pos_ff == n_cur) begin
            wt = csi_pkg::WEIGHT_S13_END;
         end else if (pos_ff[0]) begin
            wt = csi_pkg::WEIGHT_S13_ODD;
         end else begin
            wt = csi_pkg::WEIGHT_S13_EVEN;
         end
      end else if (run3_cur) begin
         if (first || pos_ff == n_cur) begin
            wt = csi_pkg::WEIGHT_S38_END;
         end else if (pos3_ff == 2'd0) begin
            wt = csi_pkg::WEIGHT_S38_THIRD;
         end else begin
            wt = csi_pkg::WEIGHT_S38_INNER;
         end
      end else if (pos_ff < n_less3) begin
         // 1/3 rule on the head of a mixed run
         if (first) begin
            wt = csi_pkg::WEIGHT_S13_END;
         end else if (pos_ff[0]) begin
            wt = csi_pkg::WEIGHT_S13_ODD;
         end else begin
            wt = csi_pkg::WEIGHT_S13_EVEN;
         end
      end else if (pos_ff == n_less3) begin
         wt = csi_pkg::WEIGHT_JOIN;
      end else if (pos_ff == n_cur) begin
         wt = csi_pkg::WEIGHT_S38_END;
      end else begin
         wt = csi_pkg::WEIGHT_S38_INNER;
      end
   end

   assign s2_free  = !out_valid_ff || out_ready;
   assign s1_free  = !s1_valid_ff || !s1_last_ff || s2_free;
   assign s1_leave = s1_valid_ff && s1_free;
   assign in_ready = s1_free;
   assign accept   = in_valid && s1_free;

   always_comb begin
      pos_in       = pos_ff;
      pos3_in      = pos3_ff;
      run_n_in     = run_n_ff;
      run3_in      = run3_ff;
      s1_valid_in  = s1_free ? accept : s1_valid_ff;
      s1_sample_in = s1_sample_ff;
      s1_weight_in = s1_weight_ff;
      s1_first_in  = s1_first_ff;
      s1_last_in   = s1_last_ff;
      if (accept) begin
         if (first) begin
            run_n_in = n_new;
            run3_in  = n3_new;
         end
         if (last) begin
            pos_in  = '0;
            pos3_in = 2'd0;
         end else begin
            pos_in  = pos_ff + 1'b1;
            pos3_in = (pos3_ff == 2'd2) ? 2'd0 : pos3_ff + 2'd1;
         end
         s1_sample_in = in_sample;
         s1_weight_in = wt;
         s1_first_in  = first;
         s1_last_in   = last;
      end
   end

   always_comb begin
      term     = s1_sample_ff * $signed({1'b0, s1_weight_ff});
      sum_base = s1_first_ff ? '0 : sum_ff;
      sum_next = sum_base + SUM_W'(term);
      sum_in   = s1_leave ? sum_next : sum_ff;
      out_valid_in = s2_free ? (s1_leave && s1_last_ff) : out_valid_ff;
      out_sum_in   = (s1_leave && s1_last_ff) ? sum_next : out_sum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         pos3_ff      <= 2'd0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         pos3_ff      <= pos3_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_n_ff     <= run_n_in;
      run3_ff      <= run3_in;
      s1_sample_ff <= s1_sample_in;
      s1_weight_ff <= s1_weight_in;
      s1_first_ff  <= s1_first_in;
      s1_last_ff   <= s1_last_in;
      sum_ff       <= sum_in;
      out_sum_ff   <= out_sum_in;
   end

   assign out_valid = out_valid_ff;
   assign out_sum   = out_sum_ff;

endmodule

`default_nettype wire

/* hw/rtl/csi_scale.sv */
`default_nettype none

module csi_scale #(
   parameter int SUM_W = csi_pkg::sum_width(csi_pkg::MAX_INTERVALS)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [csi_pkg::STEP_W-1:0]        step_size,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic signed [SUM_W-1:0]           in_sum,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic                              out_neg,
   output logic [SUM_W+csi_pkg::STEP_W-2:0]  out_prod
);

   localparam int MAG_W  = SUM_W - 1;
   localparam int HI_W   = MAG_W - 32;
   localparam int PROD_W = MAG_W + csi_pkg::STEP_W;

   logic             a_valid_ff, a_valid_in, a_neg_ff, a_neg_in;
   logic [MAG_W-1:0] a_mag_ff, a_mag_in;
   logic             b_valid_ff, b_valid_in, b_neg_ff, b_neg_in;
   logic [63:0]      b_lo_ff, b_lo_in;
   logic [MAG_W-1:0] b_hi_ff, b_hi_in;
   logic             c_valid_ff, c_valid_in, c_neg_ff, c_neg_in;
   logic [PROD_W-1:0] c_prod_ff, c_prod_in;
   logic             a_free, b_free, c_free;

   assign c_free   = !c_valid_ff || out_ready;
   assign b_free   = !b_valid_ff || c_free;
   assign a_free   = !a_valid_ff || b_free;
   assign in_ready = a_free;

   always_comb begin
      a_valid_in = a_free ? in_valid : a_valid_ff;
      a_neg_in   = a_neg_ff;
      a_mag_in   = a_mag_ff;
      if (a_free && in_valid) begin
         a_neg_in = in_sum[SUM_W-1];
         a_mag_in = in_sum[SUM_W-1] ? MAG_W'(-in_sum) : MAG_W'(in_sum);
      end

      b_valid_in = b_free ? a_valid_ff : b_valid_ff;
      b_neg_in   = b_neg_ff;
      b_lo_in    = b_lo_ff;
      b_hi_in    = b_hi_ff;
      if (b_free && a_valid_ff) begin
         b_neg_in = a_neg_ff;
         b_lo_in  = 64'(a_mag_ff[31:0]) * 64'(step_size);
         b_hi_in  = (HI_W + 32)'(a_mag_ff[MAG_W-1:32]) * (HI_W + 32)'(step_size);
      end

      c_valid_in = c_free ? b_valid_ff : c_valid_ff;
      c_neg_in   = c_neg_ff;
      c_prod_in  = c_prod_ff;
      if (c_free && b_valid_ff) begin
         c_neg_in  = b_neg_ff;
         c_prod_in = PROD_W'(b_lo_ff) + (PROD_W'(b_hi_ff) << 32);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_neg_ff  <= a_neg_in;
      a_mag_ff  <= a_mag_in;
      b_neg_ff  <= b_neg_in;
      b_lo_ff   <= b_lo_in;
      b_hi_ff   <= b_hi_in;
      c_neg_ff  <= c_neg_in;
      c_prod_ff <= c_prod_in;
   end

   assign out_valid = c_valid_ff;
   assign out_neg   = c_neg_ff;
   assign out_prod  = c_prod_ff;

endmodule

`default_nettype wire

/* hw/rtl/csi_div24.sv */
`default_nettype none

module csi_div24 #(
   parameter int PROD_W = csi_pkg::sum_width(csi_pkg::MAX_INTERVALS) + csi_pkg::STEP_W - 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic                              in_neg,
   input  logic [PROD_W-1:0]                 in_prod,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [csi_pkg::INTEGRAL_W-1:0]    out_integral,
   output logic                              out_saturated
);

   localparam int CW    = csi_pkg::CHUNK_W;
   localparam int X_W   = PROD_W - 3;
   localparam int NCH   = (X_W + CW - 1) / CW;
   localparam int XP    = NCH * CW;
   localparam int RS    = CW + 4;
   localparam int RM    = (2 ** RS + 2) / 3;
   localparam int CUR_W = CW + 2;
   localparam int RP_W  = CUR_W + RS;

   logic          st_valid_ff [NCH];
   logic          st_valid_in [NCH];
   logic          st_neg_ff   [NCH];
   logic          st_neg_in   [NCH];
   logic [1:0]    st_rem_ff   [NCH];
   logic [1:0]    st_rem_in   [NCH];
   logic [XP-1:0] st_work_ff  [NCH];
   logic [XP-1:0] st_work_in  [NCH];
   logic          st_free     [NCH+1];

   logic                           out_valid_ff, out_valid_in;
   logic [csi_pkg::INTEGRAL_W-1:0] out_integral_ff, out_integral_in;
   logic                           out_sat_ff, out_sat_in;
   logic [XP-1:0]                  q;
   logic                           pos_over, neg_over, fin_neg;

   assign in_ready     = st_free[0];
   assign st_free[NCH] = !out_valid_ff || out_ready;

   // one base-2^CW quotient digit per stage, most significant first;
   // each digit overwrites the dividend digit it consumed
   for (genvar k = 0; k < NCH; k++) begin : g_stage
      localparam int LO = (NCH - 1 - k) * CW;

      logic             src_valid, src_neg;
      logic [1:0]       src_rem;
      logic [XP-1:0]    src_work;
      logic [CUR_W-1:0] cur;
      logic [RP_W-1:0]  rprod;
      logic [CW-1:0]    digit;

      if (k == 0) begin : g_head
         assign src_valid = in_valid;
         assign src_neg   = in_neg;
         assign src_rem   = 2'd0;
         assign src_work  = XP'(in_prod >> 3);
      end else begin : g_body
         assign src_valid = st_valid_ff[k-1];
         assign src_neg   = st_neg_ff[k-1];
         assign src_rem   = st_rem_ff[k-1];
         assign src_work  = st_work_ff[k-1];
      end

      assign st_free[k] = !st_valid_ff[k] || st_free[k+1];

      always_comb begin
         cur   = {src_rem, src_work[LO +: CW]};
         rprod = RP_W'(cur) * RP_W'(RM);
         digit = CW'(rprod >> RS);
         st_valid_in[k] = st_free[k] ? src_valid : st_valid_ff[k];
         st_neg_in[k]   = st_neg_ff[k];
         st_rem_in[k]   = st_rem_ff[k];
         st_work_in[k]  = st_work_ff[k];
         if (st_free[k] && src_valid) begin
            st_neg_in[k]           = src_neg;
            st_rem_in[k]           = 2'(cur - CUR_W'(32'(digit) * 3));
            st_work_in[k]          = src_work;
            st_work_in[k][LO +: CW] = digit;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_valid_ff[k] <= 1'b0;
         end else begin
            st_valid_ff[k] <= st_valid_in[k];
         end
      end

      always_ff @(posedge clock) begin
         st_neg_ff[k]  <= st_neg_in[k];
         st_rem_ff[k]  <= st_rem_in[k];
         st_work_ff[k] <= st_work_in[k];
      end
   end

   assign q       = st_work_ff[NCH-1];
   assign fin_neg = st_neg_ff[NCH-1];

   always_comb begin
      pos_over = |q[XP-1:63];
      neg_over = (|q[XP-1:64]) || (q[63] && (|q[62:0]));
      out_valid_in    = st_free[NCH] ? st_valid_ff[NCH-1] : out_valid_ff;
      out_integral_in = out_integral_ff;
      out_sat_in      = out_sat_ff;
      if (st_free[NCH] && st_valid_ff[NCH-1]) begin
         if (!fin_neg) begin
            out_sat_in      = pos_over;
            out_integral_in = pos_over ? csi_pkg::INTEGRAL_MAX : q[63:0];
         end else begin
            out_sat_in      = neg_over;
            out_integral_in = neg_over ? csi_pkg::INTEGRAL_MIN : -q[63:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_integral_ff <= out_integral_in;
      out_sat_ff      <= out_sat_in;
   end

   assign out_valid     = out_valid_ff;
   assign out_integral  = out_integral_ff;
   assign out_saturated = out_sat_ff;

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
   import csi_pkg::*;

   localparam int SETTLE_CYCLES = 16;
   localparam int QUIET_LIMIT   = 2000;
   localparam int PHASE_BEATS   = 65;
   localparam int PRESSURE_HOLD = 400;

   typedef struct packed {
      logic [INTEGRAL_W-1:0] integral;
      logic                  saturated;
   } result_type;

   typedef enum logic {ROW_BEAT, ROW_STEP} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [31:0]  value;      // sample, or step_size on a ROW_STEP row
      logic [10:0]  count;
      logic         typed;
      result_type   want;
   } row_type;

   localparam result_type ZERO_RESULT = '{integral: '0, saturated: 1'b0};

   localparam row_type DIRECTED [27] = '{
      '{ROW_BEAT, 32'h7FFF_FFFF, 11'd0,     1'b1, ZERO_RESULT},
      '{ROW_BEAT, 32'h8000_0000, 11'd0,     1'b1, ZERO_RESULT},
      '{ROW_BEAT, 32'h0100_0000, 11'd1,     1'b0, ZERO_RESULT},
      '{ROW_BEAT, 32'h0100_0000, 11'h7FF,   1'b1, '{64'h0001_0000_0000_0000, 1'b0}},
      '{ROW_BEAT, 32'h0100_0000, 11'd2,     1'b0, ZERO_RESULT},
      '{ROW_BEAT, 32'h0100_0000, 11'd0,     1'b0, ZERO_RESULT},
      '{ROW_BEAT, 32'h0100_0000, 11'd0,     1'b1, '{64'h0002_0000_0000_0000, 1'b0}},
      '{ROW_BEAT, 32'h7FFF_FFFF, 11'd3,     1'b0, ZERO_RESULT},
      '{ROW_BEAT, 32'h8000_0000, 11'h400,   1'b0, ZERO_RESULT},
      '{ROW_BEAT, 32'h0000_0000, 11'h3FF,   1'b0, ZERO_RESULT},
      '{ROW_BEAT, 32'h1234_5678, 11'd5,     1'b0, ZERO_RESULT},
      '{ROW_BEAT, 32'hFFFF_FFFF, 11'd5,     1'b0, ZERO_RESULT},
      '{ROW_BEAT, 32'h00FF_FFFF, 11'd0,     1'b0, ZERO_RESULT},
      '{ROW_BEAT, 32'h8000_0001, 11'h555,   1'b0, ZERO_RESULT},
      '{ROW_BEAT, 32'h7FFF_FFFE, 11'h2AA,   1'b0, ZERO_RESULT},
      '{ROW_BEAT, 32'h5555_5555, 11'd1,     1'b0, ZERO_RESULT},
      '{ROW_BEAT, 32'hAAAA_AAAA, 11'd7,     1'b0, ZERO_RESULT},
      '{ROW_STEP, 32'hFFFF_FFFF, 11'd0,     1'b0, ZERO_RESULT},
      '{ROW_BEAT, 32'h7FFF_FFFF, 11'd2,     1'b0, ZERO_RESULT},
      '{ROW_BEAT, 32'h7FFF_FFFF, 11'd0,     1'b0, ZERO_RESULT},
      '{ROW_BEAT, 32'h7FFF_FFFF, 11'd0,     1'b1, '{INTEGRAL_MAX, 1'b1}},
      '{ROW_BEAT, 32'h8000_0000, 11'd2,     1'b0, ZERO_RESULT},
      '{ROW_BEAT, 32'h8000_0000, 11'd0,     1'b0, ZERO_RESULT},
      '{ROW_BEAT, 32'h8000_0000, 11'd0,     1'b1, '{INTEGRAL_MIN, 1'b1}},
      '{ROW_STEP, 32'h0000_0000, 11'd0,     1'b0, ZERO_RESULT},
      '{ROW_BEAT, 32'h7FFF_FFFF, 11'd1,     1'b0, ZERO_RESULT},
      '{ROW_BEAT, 32'h8000_0000, 11'd0,     1'b1, ZERO_RESULT}
   };

   logic                  clock;
   logic                  reset;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [STEP_W-1:0]     csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;     // sample, interval_count
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [INTEGRAL_W-1:0] rsp_tdata;     // integral
   logic [0:0]            rsp_tuser;     // saturated

   composite_simpson_integrator u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // integrator model state
   logic [STEP_W-1:0] step_now = STEP_RESET;
   int unsigned       run_pos  = 0;
   int unsigned       run_n    = 0;
   longint            run_sum  = 0;

   result_type pending_integrals [$];
   int         mismatch_count = 0;
   int         quiet_cycles = 0;
   bit         press_now = 1'b0;

   function automatic int third_rule_weight(int unsigned i, int unsigned m);
      if (i == 0 || i == m) return 8;
      if (i % 2 != 0) return 32;
      return 16;
   endfunction

   function automatic int beat_weight(int unsigned i, int unsigned n);
      if (n == 1) return 12;
      if (n % 2 == 0) return third_rule_weight(i, n);
      if (n % 3 == 0) begin
         if (i == 0 || i == n) return 9;
         if (i % 3 == 0) return 18;
         return 27;
      end
      if (i < n - 3) return third_rule_weight(i, n - 3);
      if (i == n - 3) return 17;
      if (i == n) return 9;
      return 27;
   endfunction

   // h * sum / 24, truncated toward zero, clipped to 64 bits
   function automatic result_type scale_sum(longint sum, logic [STEP_W-1:0] h);
      logic [63:0] mag;
      logic [95:0] quo;
      logic [95:0] lim;
      result_type  r;
      lim = 96'd1 << 63;
      mag = (sum < 0) ? 64'(-sum) : 64'(sum);
      quo = ({32'd0, mag} * {64'd0, h}) / 96'd24;
      if (sum >= 0) begin
         if (quo >= lim) r = '{INTEGRAL_MAX, 1'b1};
         else r = '{quo[63:0], 1'b0};
      end else begin
         if (quo > lim) r = '{INTEGRAL_MIN, 1'b1};
         else r = '{64'd0 - quo[63:0], 1'b0};
      end
      return r;
   endfunction

   task automatic integrate_sample(input logic signed [31:0] s, input logic [10:0] cnt,
                                   output bit done, output result_type r);
      int unsigned pos;
      pos  = run_pos;
      done = 1'b0;
      r    = ZERO_RESULT;
      if (pos == 0) begin
         run_n   = (cnt > MAX_INTERVALS) ? MAX_INTERVALS : cnt;
         run_sum = 0;
         if (run_n == 0) begin
            done = 1'b1;
            return;
         end
      end
      run_sum += longint'(beat_weight(pos, run_n)) * longint'(s);
      if (pos >= run_n) begin
         r       = scale_sum(run_sum, step_now);
         done    = 1'b1;
         run_pos = 0;
         run_sum = 0;
      end else begin
         run_pos = pos + 1;
      end
   endtask

   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic report(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%t: %s", $realtime, msg);
   endtask

   task automatic push_sample(input logic [31:0] s, input logic [10:0] cnt,
                              input logic typed, input result_type want,
                              input bit no_gaps);
      bit         done;
      result_type r;
      int         gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({cnt, s});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      integrate_sample(s, cnt, done, r);
      if (done) pending_integrals.push_back(typed ? want : r);
      gap = no_gaps ? 0 : idle_cycles();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic write_step(input logic [STEP_W-1:0] h);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_integrals.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      req_tvalid <= 1'b0;
      csr_valid  <= 1'b1;
      csr_wdata  <= h;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      step_now = h;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // result checker
   result_type rsp_got;
   result_type rsp_want;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_got = '{rsp_tdata, rsp_tuser[0]};
         if (pending_integrals.size() == 0) begin
            report($sformatf("unexpected result integral=%h saturated=%b",
                             rsp_got.integral, rsp_got.saturated));
         end else begin
            rsp_want = pending_integrals.pop_front();
            if (rsp_got !== rsp_want)
               report($sformatf("integral exp=%h got=%h  saturated exp=%b got=%b",
                                rsp_want.integral, rsp_got.integral,
                                rsp_want.saturated, rsp_got.saturated));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result sink: random stalls, one long hold to back the block up
   initial begin
      int  stall;
      int  open_run;
      bit  pressed;
      pressed    = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         stall = idle_cycles();
         if (!pressed && press_now) begin
            stall   = PRESSURE_HOLD;
            pressed = 1'b1;
         end
         if (stall > 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         open_run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 20);
         for (int k = 1; k < open_run; k++) begin
            @(negedge clock);
            if (!pressed && press_now) break;
         end
      end
   end

   initial begin
      logic [STEP_W-1:0] phase_step [6];
      logic [10:0]       cnt;
      logic [31:0]       s;
      int unsigned       n_beats;
      int                beats;
      int                r;
      bit                no_gaps;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_wdata  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].kind == ROW_STEP) write_step(DIRECTED[i].value);
         else push_sample(DIRECTED[i].value, DIRECTED[i].count, DIRECTED[i].typed,
                          DIRECTED[i].want, 1'b0);
      end

      phase_step[0] = 32'h0000_0001;
      phase_step[1] = $urandom;
      phase_step[2] = STEP_RESET;
      phase_step[3] = $urandom_range(32'h0040_0000, 32'h0400_0000);
      phase_step[4] = 32'hFFFF_FFFF;
      phase_step[5] = $urandom;

      foreach (phase_step[ph]) begin
         write_step(phase_step[ph]);
         // short runs back to back while the sink holds off
         if (ph == 1) press_now = 1'b1;
         beats = 0;
         while (beats < PHASE_BEATS) begin
            r = $urandom_range(0, 99);
            if (ph == 1) cnt = 11'($urandom_range(0, 3));
            else if (r < 8) cnt = 11'd0;
            else if (r < 75) cnt = 11'($urandom_range(1, 12));
            else cnt = 11'($urandom_range(13, 64));
            n_beats = ((cnt > MAX_INTERVALS) ? MAX_INTERVALS : cnt) + 1;
            no_gaps = (ph == 1) || ($urandom_range(0, 3) == 0);
            for (int k = 0; k < n_beats; k++) begin
               r = $urandom_range(0, 99);
               if (r < 10) s = 32'h7FFF_FFFF;
               else if (r < 20) s = 32'h8000_0000;
               else if (r < 45) s = 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
               else s = $urandom;
               push_sample(s, (k == 0) ? cnt : 11'($urandom_range(0, 2047)), 1'b0,
                           ZERO_RESULT, no_gaps);
            end
            beats += n_beats;
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_integrals.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

/* composite_simpson_integrator.f */
hw/rtl/csi_pkg.sv
hw/rtl/csi_front.sv
hw/rtl/csi_scale.sv
hw/rtl/csi_div24.sv
hw/rtl/composite_simpson_integrator.sv
tb/sv/testbench.sv
